[src/sci_pkg.sv]
// ----------------------------------------------------------------------------
// sci_pkg
// Shared types for the segment and circle intersection pipeline.
// ----------------------------------------------------------------------------
package sci_pkg;

    // Number of root cells and of quotient cells in the two chains.
    localparam int SqrtSteps = 32;
    localparam int DivSteps  = 16;

    // Depth that stands for 1.0 in Q1.16.
    localparam logic [16:0] DepthOne = 17'h10000;

    // One input request.
    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] ray_dx;
        logic signed [15:0] ray_dy;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic        [10:0] radius;
    } in_t;

    // One result request.
    typedef struct packed {
        logic        hit;
        logic [16:0] depth;
    } out_t;

    // Data handed along the square root chain.
    typedef struct packed {
        logic [63:0]        rad;
        logic [33:0]        rem;
        logic [31:0]        root;
        logic [31:0]        a;
        logic signed [33:0] h;
        logic               in_circle;
        logic               miss;
    } sqrt_t;

    // Data handed along the divider chain.
    typedef struct packed {
        logic [31:0] r;
        logic [31:0] a;
        logic [16:0] q;
        logic        in_circle;
        logic        found;
    } div_t;

endpackage

[src/sci_front.sv]
// ----------------------------------------------------------------------------
// sci_front
// Seven stage set-up pipeline: offsets, products, sums, the inside test
// and the quarter discriminant that feeds the square root chain.
// ----------------------------------------------------------------------------
module sci_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sci_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sci_pkg::sqrt_t  out_data
);

    typedef struct packed {
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic        [14:0] r;
    } s1_t;

    typedef struct packed {
        logic [31:0]        pxx;
        logic [31:0]        pyy;
        logic [30:0]        dxx;
        logic [30:0]        dyy;
        logic signed [32:0] hx;
        logic signed [32:0] hy;
        logic [29:0]        rr;
    } s2_t;

    typedef struct packed {
        logic [32:0]        pp;
        logic [31:0]        a;
        logic signed [33:0] h;
        logic [29:0]        rr;
    } s3_t;

    typedef struct packed {
        logic               in_circle;
        logic [32:0]        c;
        logic [31:0]        habs;
        logic [31:0]        a;
        logic signed [33:0] h;
    } s4_t;

    typedef struct packed {
        logic [63:0]        hh;
        logic [48:0]        ac_lo;
        logic [47:0]        ac_hi;
        logic [31:0]        a;
        logic signed [33:0] h;
        logic               in_circle;
    } s5_t;

    typedef struct packed {
        logic [63:0]        hh;
        logic [63:0]        ac;
        logic [31:0]        a;
        logic signed [33:0] h;
        logic               in_circle;
    } s6_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

    s1_t            s1_reg, s1_next;
    s2_t            s2_reg, s2_next;
    s3_t            s3_reg, s3_next;
    s4_t            s4_reg, s4_next;
    s5_t            s5_reg, s5_next;
    s6_t            s6_reg, s6_next;
    sci_pkg::sqrt_t s7_reg, s7_next;
    logic [64:0]    diff;

    // A stage loads when it is empty or when its contents move on.
    assign rdy7     = !v7_reg || out_ready;
    assign rdy6     = !v6_reg || rdy7;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
            if (rdy7) v7_reg <= v6_reg;
        end
    end

    // Stage one: start relative to the centre, radius in Q.4.
    always_comb
    begin
        s1_next.px = {in_data.start_x[15], in_data.start_x}
                   - {in_data.center_x[15], in_data.center_x};
        s1_next.py = {in_data.start_y[15], in_data.start_y}
                   - {in_data.center_y[15], in_data.center_y};
        s1_next.dx = in_data.ray_dx;
        s1_next.dy = in_data.ray_dy;
        s1_next.r  = {in_data.radius, 4'b0000};
    end

    // Stage two: all squares and cross products side by side.
    always_comb
    begin
        s2_next.pxx = 32'(s1_reg.px * s1_reg.px);
        s2_next.pyy = 32'(s1_reg.py * s1_reg.py);
        s2_next.dxx = 31'(s1_reg.dx * s1_reg.dx);
        s2_next.dyy = 31'(s1_reg.dy * s1_reg.dy);
        s2_next.hx  = s1_reg.dx * s1_reg.px;
        s2_next.hy  = s1_reg.dy * s1_reg.py;
        s2_next.rr  = s1_reg.r * s1_reg.r;
    end

    // Stage three: dot products.
    always_comb
    begin
        s3_next.pp = {1'b0, s2_reg.pxx} + {1'b0, s2_reg.pyy};
        s3_next.a  = {1'b0, s2_reg.dxx} + {1'b0, s2_reg.dyy};
        s3_next.h  = {s2_reg.hx[32], s2_reg.hx} + {s2_reg.hy[32], s2_reg.hy};
        s3_next.rr = s2_reg.rr;
    end

    // Stage four: inside test, constant term and magnitude of h.
    always_comb
    begin
        s4_next.in_circle = s3_reg.pp < {3'b000, s3_reg.rr};
        s4_next.c         = s3_reg.pp - {3'b000, s3_reg.rr};
        s4_next.habs      = s3_reg.h[33] ? 32'(-s3_reg.h) : s3_reg.h[31:0];
        s4_next.a         = s3_reg.a;
        s4_next.h         = s3_reg.h;
    end

    // Stage five: h squared and a*c in two partial products.
    always_comb
    begin
        s5_next.hh        = s4_reg.habs * s4_reg.habs;
        s5_next.ac_lo     = s4_reg.a * s4_reg.c[16:0];
        s5_next.ac_hi     = s4_reg.a * s4_reg.c[32:17];
        s5_next.a         = s4_reg.a;
        s5_next.h         = s4_reg.h;
        s5_next.in_circle = s4_reg.in_circle;
    end

    // Stage six: join the partial products.
    always_comb
    begin
        s6_next.hh        = s5_reg.hh;
        s6_next.ac        = {15'b0, s5_reg.ac_lo} + {s5_reg.ac_hi[46:0], 17'b0};
        s6_next.a         = s5_reg.a;
        s6_next.h         = s5_reg.h;
        s6_next.in_circle = s5_reg.in_circle;
    end

    // Stage seven: quarter discriminant; its sign and a zero length mean a miss.
    always_comb
    begin
        diff              = {1'b0, s6_reg.hh} - {1'b0, s6_reg.ac};
        s7_next.rad       = diff[63:0];
        s7_next.rem       = '0;
        s7_next.root      = '0;
        s7_next.a         = s6_reg.a;
        s7_next.h         = s6_reg.h;
        s7_next.in_circle = s6_reg.in_circle;
        s7_next.miss      = diff[64] || (s6_reg.a == 32'd0);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid) s1_reg <= s1_next;
        if (rdy2 && v1_reg)   s2_reg <= s2_next;
        if (rdy3 && v2_reg)   s3_reg <= s3_next;
        if (rdy4 && v3_reg)   s4_reg <= s4_next;
        if (rdy5 && v4_reg)   s5_reg <= s5_next;
        if (rdy6 && v5_reg)   s6_reg <= s6_next;
        if (rdy7 && v6_reg)   s7_reg <= s7_next;
    end

    assign out_valid = v7_reg;
    assign out_data  = s7_reg;

endmodule

[src/sci_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// sci_sqrt_cell
// One digit of the integer square root: brings down two radicand bits and
// decides one root bit.
// ----------------------------------------------------------------------------
module sci_sqrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sci_pkg::sqrt_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sci_pkg::sqrt_t  out_data
);

    logic           v_reg;
    sci_pkg::sqrt_t d_reg, d_next;
    logic [34:0]    rem_sh;
    logic [34:0]    trial;
    logic           ge;

    assign in_ready = !v_reg || out_ready;

    // Trial subtraction of 4*root + 1 from the shifted remainder.
    always_comb
    begin
        rem_sh      = {in_data.rem[32:0], in_data.rad[63:62]};
        trial       = {1'b0, in_data.root, 2'b01};
        ge          = rem_sh >= trial;
        d_next      = in_data;
        d_next.rad  = {in_data.rad[61:0], 2'b00};
        d_next.rem  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        d_next.root = {in_data.root[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

[src/sci_root_sel.sv]
// ----------------------------------------------------------------------------
// sci_root_sel
// Picks the first root in range, larger one first, and prepares the
// remainder and top quotient bit for the divider chain.
// ----------------------------------------------------------------------------
module sci_root_sel (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sci_pkg::sqrt_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sci_pkg::div_t   out_data
);

    typedef struct packed {
        logic [31:0] n;
        logic [31:0] a;
        logic        in_circle;
        logic        found;
    } sel_t;

    logic               v1_reg, v2_reg;
    logic               rdy1, rdy2;
    sel_t               p1_reg, p1_next;
    sci_pkg::div_t      p2_reg, p2_next;
    logic signed [34:0] n1;
    logic signed [34:0] n2;
    logic               ok1;
    logic               ok2;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Both numerators, each checked against [0, a].
    always_comb
    begin
        n1  = {3'b000, in_data.root} - {in_data.h[33], in_data.h};
        n2  = -{in_data.h[33], in_data.h} - {3'b000, in_data.root};
        ok1 = !n1[34] && (n1[33:0] <= {2'b00, in_data.a});
        ok2 = !n2[34] && (n2[33:0] <= {2'b00, in_data.a});
        p1_next.n         = ok1 ? n1[31:0] : n2[31:0];
        p1_next.a         = in_data.a;
        p1_next.in_circle = in_data.in_circle;
        p1_next.found     = !in_data.in_circle && !in_data.miss && (ok1 || ok2);
    end

    // A zero numerator gives depth one; otherwise a - n stays below a.
    always_comb
    begin
        p2_next.a         = p1_reg.a;
        p2_next.in_circle = p1_reg.in_circle;
        p2_next.found     = p1_reg.found;
        if (p1_reg.n == 32'd0)
        begin
            p2_next.r = '0;
            p2_next.q = 17'd1;
        end
        else
        begin
            p2_next.r = p1_reg.a - p1_reg.n;
            p2_next.q = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid) p1_reg <= p1_next;
        if (rdy2 && v1_reg)   p2_reg <= p2_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = p2_reg;

endmodule

[src/sci_div_cell.sv]
// ----------------------------------------------------------------------------
// sci_div_cell
// One step of restoring division: doubles the remainder and decides one
// quotient bit against the segment length term.
// ----------------------------------------------------------------------------
module sci_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sci_pkg::div_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output sci_pkg::div_t  out_data
);

    logic          v_reg;
    sci_pkg::div_t d_reg, d_next;
    logic [32:0]   r2;
    logic          ge;

    assign in_ready = !v_reg || out_ready;

    // Shift and subtract; the remainder always stays below a.
    always_comb
    begin
        r2       = {in_data.r, 1'b0};
        ge       = r2 >= {1'b0, in_data.a};
        d_next   = in_data;
        d_next.r = ge ? 32'(r2 - {1'b0, in_data.a}) : r2[31:0];
        d_next.q = {in_data.q[15:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

[src/segment_circle_intersection.sv]
// ----------------------------------------------------------------------------
// segment_circle_intersection
// Segment against circle hit test with the depth 1 - t of the larger root in range.
// ----------------------------------------------------------------------------
// Usage:
// A request on in_data (start, vector, centre in Q12.4, radius in whole
// units) is taken when in_valid and in_ready are both high. Each request
// gives exactly one result on out_data (hit, depth in Q1.16), offered with
// out_valid until out_ready takes it.
// The path is 7 set-up stages, 32 square root cells, 2 root selection
// stages and 16 divider cells. While the receiver does not stall, the
// throughput is one request per cycle, set by the chains of cells, each
// of which does one digit per cycle. When the receiver stalls, the last
// cell holds its result; the ready signals run back through every stage
// in the same cycle, so empty stages still fill and new requests are taken
// until the pipeline is full, at which point in_ready drops at once.
// Reset clears every stage's valid flag; no result is offered until a
// request has passed through. There are no registers to set up.
// ----------------------------------------------------------------------------
module segment_circle_intersection (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sci_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output sci_pkg::out_t  out_data
);

    logic           sq_valid [sci_pkg::SqrtSteps+1];
    logic           sq_ready [sci_pkg::SqrtSteps+1];
    sci_pkg::sqrt_t sq_data  [sci_pkg::SqrtSteps+1];

    logic           dv_valid [sci_pkg::DivSteps+1];
    logic           dv_ready [sci_pkg::DivSteps+1];
    sci_pkg::div_t  dv_data  [sci_pkg::DivSteps+1];

    sci_pkg::div_t  last;

    // Set-up pipeline.
    sci_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (sq_valid[0]),
        .out_ready (sq_ready[0]),
        .out_data  (sq_data[0])
    );

    // Square root chain, one root bit per cell.
    for (genvar i = 0; i < sci_pkg::SqrtSteps; i++)
    begin : g_sqrt
        sci_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .in_data   (sq_data[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .out_data  (sq_data[i+1])
        );
    end

    // Root selection.
    sci_root_sel u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid[sci_pkg::SqrtSteps]),
        .in_ready  (sq_ready[sci_pkg::SqrtSteps]),
        .in_data   (sq_data[sci_pkg::SqrtSteps]),
        .out_valid (dv_valid[0]),
        .out_ready (dv_ready[0]),
        .out_data  (dv_data[0])
    );

    // Divider chain, one quotient bit per cell.
    for (genvar j = 0; j < sci_pkg::DivSteps; j++)
    begin : g_div
        sci_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[j]),
            .in_ready  (dv_ready[j]),
            .in_data   (dv_data[j]),
            .out_valid (dv_valid[j+1]),
            .out_ready (dv_ready[j+1]),
            .out_data  (dv_data[j+1])
        );
    end

    // The last divider cell is the output register.
    assign last                          = dv_data[sci_pkg::DivSteps];
    assign dv_ready[sci_pkg::DivSteps]   = out_ready;
    assign out_valid                     = dv_valid[sci_pkg::DivSteps];

    // Result: inside wins, then a root in range, otherwise a miss.
    always_comb
    begin
        if (last.in_circle)
        begin
            out_data.hit   = 1'b1;
            out_data.depth = sci_pkg::DepthOne;
        end
        else if (last.found)
        begin
            out_data.hit   = 1'b1;
            out_data.depth = last.q;
        end
        else
        begin
            out_data.hit   = 1'b0;
            out_data.depth = '0;
        end
    end

    // A miss never carries a depth.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.depth == 17'd0)
        else $error("miss with non-zero depth");

    // The depth never exceeds one.
    a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.depth <= sci_pkg::DepthOne)
        else $error("depth above one");

    // With the receiver ready the whole pipeline moves, so input is taken.
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is ready");

endmodule
